[rtl/core/assert_macros.svh]
// assertion macros used by the checker rpf_checker
// expects signals named clk and rst_n in the module that uses them
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled while in reset
`define ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled while in reset
`define ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/core/rpf_pkg.sv]
// types and constants for the rgb palette fader
// no dependencies; imported by every module of the block
`default_nettype none

package rpf_pkg;

  localparam int CHAN_W       = 8;
  localparam int NUM_CHAN     = 3;
  localparam int COLOR_W      = CHAN_W * NUM_CHAN;
  localparam int PALETTE_SIZE = 6;
  localparam int PIDX_W       = 3;
  localparam int CFG_IDX_W    = 3;
  localparam int BIT_CNT_W    = 3;
  localparam int CH_W         = 2;

  // register indexes on the config port
  localparam logic [CFG_IDX_W-1:0] REG_PALETTE_COUNT = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FADE_STEPS    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_COLOR_ZERO    = 3'd2;

  localparam logic [PIDX_W-1:0]    PALETTE_MAX       = 3'd6;
  localparam logic [CHAN_W-1:0]    FADE_STEPS_RST    = 8'd32;
  localparam logic [CH_W-1:0]      CH_LAST           = 2'd2;

  // commands from the controller to the datapath
  typedef struct packed {
    logic            load_tgt;   // latch target, advance palette index
    logic            div_init;   // load |diff| of channel ch into divider
    logic            div_iter;   // one restoring divide step
    logic            div_store;  // write finished step size of channel ch
    logic [CH_W-1:0] ch;         // 0 blue, 1 green, 2 red
    logic            move;       // step all channels, load output register
  } cmd_t;

  // status from the datapath to the controller
  typedef struct packed {
    logic fading;
    logic out_busy;
  } status_t;

endpackage

`default_nettype wire

[rtl/core/rpf_dpath.sv]
// datapath: config registers, color state, shared serial divider, output register
// depends on rpf_pkg
`default_nettype none

module rpf_dpath
  import rpf_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 cfg_we,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [COLOR_W-1:0]   cfg_data,
  input  wire cmd_t                 cmd,
  output status_t                   status,
  input  wire logic                 out_tready,
  output logic                      out_tvalid,
  output logic [COLOR_W-1:0]        out_tdata,
  output logic                      out_tlast
);

  logic [PIDX_W-1:0]  pcount_r;
  logic [CHAN_W-1:0]  fsteps_r;
  logic [COLOR_W-1:0] palette_r [PALETTE_SIZE];

  logic [COLOR_W-1:0] cur_r, cur_nxt;
  logic [COLOR_W-1:0] tgt_r;
  logic [COLOR_W-1:0] step_r;
  logic [PIDX_W-1:0]  pidx_r;
  logic               fading_r;

  logic [CHAN_W-1:0]  quo_r;
  logic [CHAN_W-1:0]  rem_r;

  logic               out_valid_r;
  logic [COLOR_W-1:0] out_data_r;
  logic               out_last_r;

  logic [PIDX_W-1:0]  n_use;
  logic [PIDX_W-1:0]  idx;
  logic [PIDX_W-1:0]  idx_inc;
  logic [PIDX_W-1:0]  pidx_nxt;
  logic [CFG_IDX_W-1:0] pal_wr;

  logic [CHAN_W-1:0]  divisor;
  logic [CHAN_W-1:0]  cur_ch, tgt_ch, diff_ch;
  logic [CHAN_W:0]    trial;
  logic [CHAN_W-1:0]  step_new;
  logic [4:0]         ch_lsb;
  logic               reached;

  // palette selection with count clamping
  always_comb begin
    if (pcount_r == '0) begin
      n_use = 3'd1;
    end else if (pcount_r > PALETTE_MAX) begin
      n_use = PALETTE_MAX;
    end else begin
      n_use = pcount_r;
    end
    idx      = (pidx_r < n_use) ? pidx_r : '0;
    idx_inc  = idx + 3'd1;
    pidx_nxt = (idx_inc >= n_use) ? '0 : idx_inc;
  end

  assign pal_wr = cfg_index - REG_COLOR_ZERO;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pcount_r <= 3'd1;
      fsteps_r <= FADE_STEPS_RST;
      for (int i = 0; i < PALETTE_SIZE; i++) begin
        palette_r[i] <= '0;
      end
    end else if (cfg_we) begin
      if (cfg_index == REG_PALETTE_COUNT) begin
        pcount_r <= cfg_data[PIDX_W-1:0];
      end else if (cfg_index == REG_FADE_STEPS) begin
        fsteps_r <= cfg_data[CHAN_W-1:0];
      end else begin
        palette_r[pal_wr] <= cfg_data;
      end
    end
  end

  // channel picked by the controller for the divider
  assign ch_lsb  = {cmd.ch, 3'b000};
  assign cur_ch  = cur_r[ch_lsb +: CHAN_W];
  assign tgt_ch  = tgt_r[ch_lsb +: CHAN_W];
  assign diff_ch = (cur_ch > tgt_ch) ? (cur_ch - tgt_ch) : (tgt_ch - cur_ch);
  assign divisor = (fsteps_r == '0) ? 8'd1 : fsteps_r;

  // restoring divide: shift one dividend bit into the remainder each step
  assign trial = {rem_r, quo_r[CHAN_W-1]} - {1'b0, divisor};

  always_ff @(posedge clk) begin
    if (cmd.div_init) begin
      quo_r <= diff_ch;
      rem_r <= '0;
    end else if (cmd.div_iter) begin
      if (!trial[CHAN_W]) begin
        rem_r <= trial[CHAN_W-1:0];
        quo_r <= {quo_r[CHAN_W-2:0], 1'b1};
      end else begin
        rem_r <= {rem_r[CHAN_W-2:0], quo_r[CHAN_W-1]};
        quo_r <= {quo_r[CHAN_W-2:0], 1'b0};
      end
    end
  end

  always_comb begin
    if (cur_ch == tgt_ch) begin
      step_new = '0;
    end else if (quo_r == '0) begin
      step_new = 8'd1;
    end else begin
      step_new = quo_r;
    end
  end

  // move every channel one step toward the target, stopping on it
  always_comb begin
    for (int c = 0; c < NUM_CHAN; c++) begin
      logic [CHAN_W-1:0] cv, tv, sv;
      cv = cur_r[c*CHAN_W +: CHAN_W];
      tv = tgt_r[c*CHAN_W +: CHAN_W];
      sv = step_r[c*CHAN_W +: CHAN_W];
      if (cv > tv) begin
        cur_nxt[c*CHAN_W +: CHAN_W] = ((cv - tv) <= sv) ? tv : (cv - sv);
      end else if (cv < tv) begin
        cur_nxt[c*CHAN_W +: CHAN_W] = ((tv - cv) <= sv) ? tv : (cv + sv);
      end else begin
        cur_nxt[c*CHAN_W +: CHAN_W] = cv;
      end
    end
  end

  assign reached = (cur_nxt == tgt_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_r    <= '0;
      tgt_r    <= '0;
      step_r   <= '0;
      pidx_r   <= '0;
      fading_r <= 1'b0;
    end else begin
      if (cmd.load_tgt) begin
        tgt_r    <= palette_r[idx];
        pidx_r   <= pidx_nxt;
        fading_r <= 1'b1;
      end
      if (cmd.div_store) begin
        step_r[ch_lsb +: CHAN_W] <= step_new;
      end
      if (cmd.move) begin
        cur_r    <= cur_nxt;
        fading_r <= !reached;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.move) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  // red goes out in the low byte
  always_ff @(posedge clk) begin
    if (cmd.move) begin
      out_data_r <= {cur_nxt[7:0], cur_nxt[15:8], cur_nxt[23:16]};
      out_last_r <= reached;
    end
  end

  assign status.fading   = fading_r;
  assign status.out_busy = out_valid_r && !out_tready;
  assign out_tvalid      = out_valid_r;
  assign out_tdata       = out_data_r;
  assign out_tlast       = out_last_r;

endmodule

`default_nettype wire

[rtl/core/rpf_ctrl.sv]
// controller: sequences target load, per-channel divide and color step
// depends on rpf_pkg; drives the datapath through cmd_t
`default_nettype none

module rpf_ctrl
  import rpf_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic in_tvalid,
  input  wire logic tick,
  output logic      in_tready,
  input  wire status_t status,
  output cmd_t      cmd
);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_LOAD   = 3'd1;
  localparam logic [2:0] S_DINIT  = 3'd2;
  localparam logic [2:0] S_DITER  = 3'd3;
  localparam logic [2:0] S_DSTORE = 3'd4;
  localparam logic [2:0] S_MOVE   = 3'd5;

  logic [2:0]           state_r, state_nxt;
  logic [CH_W-1:0]      ch_r, ch_nxt;
  logic [BIT_CNT_W-1:0] bit_r, bit_nxt;

  always_comb begin
    state_nxt     = state_r;
    ch_nxt        = ch_r;
    bit_nxt       = bit_r;
    in_tready     = 1'b0;
    cmd           = '0;
    cmd.ch        = ch_r;
    unique case (state_r)
      S_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid && tick) begin
          state_nxt = status.fading ? S_MOVE : S_LOAD;
        end
      end
      S_LOAD: begin
        cmd.load_tgt = 1'b1;
        ch_nxt       = '0;
        state_nxt    = S_DINIT;
      end
      S_DINIT: begin
        cmd.div_init = 1'b1;
        bit_nxt      = '0;
        state_nxt    = S_DITER;
      end
      S_DITER: begin
        cmd.div_iter = 1'b1;
        bit_nxt      = bit_r + 3'd1;
        if (bit_r == '1) begin
          state_nxt = S_DSTORE;
        end
      end
      S_DSTORE: begin
        cmd.div_store = 1'b1;
        if (ch_r == CH_LAST) begin
          state_nxt = S_IDLE;
        end else begin
          ch_nxt    = ch_r + 2'd1;
          state_nxt = S_DINIT;
        end
      end
      S_MOVE: begin
        // wait for the output register to free up
        if (!status.out_busy) begin
          cmd.move  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      ch_r    <= '0;
      bit_r   <= '0;
    end else begin
      state_r <= state_nxt;
      ch_r    <= ch_nxt;
      bit_r   <= bit_nxt;
    end
  end

endmodule

`default_nettype wire

[rtl/core/rgb_palette_fader.sv]
// top level of the rgb palette fader: controller plus datapath
// depends on rpf_pkg, rpf_ctrl, rpf_dpath
//
//  channel | dir | handshake             | payload
//  --------+-----+-----------------------+-------------------------------------
//  in      | in  | in_tvalid/in_tready   | in_tdata[0] tick
//  out     | out | out_tvalid/out_tready | out_tdata red,green,blue; tlast reached
//  cfg     | in  | cfg_valid/cfg_ready   | cfg_index register, cfg_data value
//
// a tick that starts a fade is accepted, loads the target, then runs each channel
// in turn through the shared 8-step restoring divider (blue, green, red).
// a tick during a fade gives one output word, and waits while the output register
// is held by out_tready low. a zero tick is accepted and does nothing.
// reset (rst_n low, synchronous) clears state, palette and registers to defaults.
// cfg_ready is always high.
`default_nettype none

module rgb_palette_fader
  import rpf_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_tvalid,
  output logic                      in_tready,
  input  wire logic [7:0]           in_tdata,    // [0] tick, [7:1] zero fill
  output logic                      out_tvalid,
  input  wire logic                 out_tready,
  output logic [COLOR_W-1:0]        out_tdata,   // [7:0] red, [15:8] green, [23:16] blue
  output logic                      out_tlast,   // reached
  input  wire logic                 cfg_valid,
  output logic                      cfg_ready,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [COLOR_W-1:0]   cfg_data
);

  cmd_t    cmd;
  status_t status;

  assign cfg_ready = 1'b1;

  rpf_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .tick      (in_tdata[0]),
    .in_tready (in_tready),
    .status    (status),
    .cmd       (cmd)
  );

  rpf_dpath u_dpath (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_valid),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .cmd        (cmd),
    .status     (status),
    .out_tready (out_tready),
    .out_tvalid (out_tvalid),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

endmodule

`default_nettype wire

[rtl/core/rpf_checker.sv]
// port-level checks for the rgb palette fader, bound to the top level
// depends on rpf_pkg and assert_macros.svh
`default_nettype none
`include "assert_macros.svh"

module rpf_checker
  import rpf_pkg::*;
(
  input wire logic                 clk,
  input wire logic                 rst_n,
  input wire logic                 in_tvalid,
  input wire logic                 in_tready,
  input wire logic [7:0]           in_tdata,
  input wire logic                 out_tvalid,
  input wire logic                 out_tready,
  input wire logic [COLOR_W-1:0]   out_tdata,
  input wire logic                 out_tlast,
  input wire logic                 cfg_valid,
  input wire logic                 cfg_ready
);

  // a stalled output word holds
  `ASSERT_NEXT(a_out_hold, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata) && $stable(out_tlast), "output word changed while stalled")

  // an accepted real tick makes the block drop in_tready
  `ASSERT_NEXT(a_busy_after_tick, in_tvalid && in_tready && in_tdata[0], !in_tready, "accepted a tick back to back")

  // a new output word only follows work in the controller, never a plain idle state
  `ASSERT_IMP(a_out_from_work, $rose(out_tvalid), !$past(in_tready), "output word appeared without a fading tick")

  // config port never stalls
  `ASSERT_IMP(a_cfg_ready, cfg_valid, cfg_ready, "config write stalled")

endmodule

bind rgb_palette_fader rpf_checker u_rpf_checker (.*);

`default_nettype wire
